// ----- src/arans_pkg.sv -----
// ----------------------------------------------------------------------------
// arans_pkg
// Types, widths and codes shared by the adaptive rANS symbol model.
// ----------------------------------------------------------------------------
package arans_pkg;

  localparam int SCALE_BITS  = 14;
  localparam int SCALE_SLOTS = 1 << SCALE_BITS;
  localparam int NSYM        = 256;

  localparam int MODE_W     = 3;
  localparam int SYM_W      = 8;
  localparam int SLOT_W     = 14;
  localparam int NFREQ_W    = 15;
  localparam int RSTART_W   = 14;

  localparam int CNT_W      = 27;
  localparam int TOT_W      = 28;
  localparam int NORM_W     = SCALE_BITS + 1;
  localparam int SUM_W      = NORM_W + SYM_W;
  localparam int IDX_W      = SYM_W + 1;
  localparam int DIV_STEPS  = SCALE_BITS + 1;
  localparam int DIV_STEP_W = $clog2(DIV_STEPS + 1);

  typedef logic [SYM_W-1:0]      sym_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [TOT_W-1:0]      tot_t;
  typedef logic [TOT_W:0]        rem_t;
  typedef logic [NORM_W-1:0]     norm_t;
  typedef logic [SUM_W-1:0]      sum_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [SCALE_BITS-1:0] slot_idx_t;
  typedef logic [DIV_STEP_W-1:0] div_step_t;
  typedef logic [MODE_W-1:0]     mode_t;

  localparam tot_t  HALVE_LIMIT = tot_t'(1 << 27);
  localparam tot_t  TOTAL_RESET = tot_t'(NSYM);
  localparam idx_t  IDX_LAST    = idx_t'(NSYM - 1);
  localparam idx_t  IDX_END     = idx_t'(NSYM);

  localparam mode_t MODE_UPDATE  = 3'd0;
  localparam mode_t MODE_SWAP    = 3'd1;
  localparam mode_t MODE_REBUILD = 3'd2;
  localparam mode_t MODE_QUERY   = 3'd3;
  localparam mode_t MODE_LOOKUP  = 3'd4;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [SYM_W-1:0]  symbol;
    logic [SLOT_W-1:0] slot;
  } in_item_t;

  typedef struct packed {
    logic [NFREQ_W-1:0]  norm_freq;
    logic [RSTART_W-1:0] range_start;
    logic [SYM_W-1:0]    symbol_out;
  } out_item_t;

  typedef struct packed {
    logic start;
    cnt_t num;
    tot_t den;
  } div_req_t;

  typedef struct packed {
    logic  done;
    norm_t quot;
  } div_rsp_t;

  typedef enum logic [4:0] {
    ST_INIT,
    ST_IDLE,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_HALVE,
    ST_SWP_RD,
    ST_SWP_ORD,
    ST_SWP_W1,
    ST_SWP_W2,
    ST_SWP_W3,
    ST_QRY,
    ST_QRY_CAP,
    ST_LKP,
    ST_LKP_CAP,
    ST_RB_RD,
    ST_RB_GO,
    ST_RB_DIV,
    ST_ADJ_CHK,
    ST_ADJ_SCAN,
    ST_ADJ_FIX,
    ST_LAY_ORD,
    ST_LAY_NRM,
    ST_LAY_HEAD,
    ST_LAY_FILL,
    ST_RESP
  } core_state_t;

endpackage

// ----- src/arans_div.sv -----
// ----------------------------------------------------------------------------
// arans_div
// Restoring divider giving floor(num * 2^SCALE_BITS / den), one bit a cycle.
// ----------------------------------------------------------------------------
module arans_div (
  input  logic                clk,
  input  logic                rst_n,
  input  arans_pkg::div_req_t req,
  output arans_pkg::div_rsp_t rsp
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  arans_pkg::div_step_t step_r, step_nxt;
  arans_pkg::rem_t      rem_r, rem_nxt;
  arans_pkg::tot_t      den_r, den_nxt;
  arans_pkg::norm_t     quot_r, quot_nxt;

  logic            cmp;
  arans_pkg::rem_t diff;
  arans_pkg::tot_t rsel;

  always_comb begin
    cmp      = rem_r >= {1'b0, den_r};
    diff     = rem_r - {1'b0, den_r};
    rsel     = cmp ? diff[arans_pkg::TOT_W-1:0] : rem_r[arans_pkg::TOT_W-1:0];
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quot_nxt = quot_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = arans_pkg::div_step_t'(arans_pkg::DIV_STEPS);
      rem_nxt  = arans_pkg::rem_t'(req.num);
      den_nxt  = req.den;
      quot_nxt = '0;
    end else if (busy_r) begin
      // The remainder stays below the divisor, so doubling it cannot overflow.
      rem_nxt  = {rsel, 1'b0};
      quot_nxt = {quot_r[arans_pkg::NORM_W-2:0], cmp};
      step_nxt = step_r - arans_pkg::div_step_t'(1);
      if (step_r == arans_pkg::div_step_t'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quot_r <= quot_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

// ----- src/arans_core.sv -----
// ----------------------------------------------------------------------------
// arans_core
// Sequencer and table memories of the symbol model; one word at a time.
// ----------------------------------------------------------------------------
module arans_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  arans_pkg::in_item_t  req_data,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output arans_pkg::out_item_t rsp_data
);

  arans_pkg::core_state_t state_r, state_nxt;

  arans_pkg::idx_t      idx_r, idx_nxt;
  arans_pkg::in_item_t  item_r, item_nxt;
  arans_pkg::tot_t      total_r, total_nxt;
  arans_pkg::sum_t      sum_r, sum_nxt;
  arans_pkg::sym_t      best_r, best_nxt;
  arans_pkg::norm_t     bv_r, bv_nxt;
  logic                 found_r, found_nxt;
  logic                 down_r, down_nxt;
  arans_pkg::sym_t      p_r, p_nxt;
  arans_pkg::sym_t      other_r, other_nxt;
  arans_pkg::sym_t      lsym_r, lsym_nxt;
  arans_pkg::norm_t     pos_r, pos_nxt;
  arans_pkg::norm_t     rem_r, rem_nxt;
  arans_pkg::out_item_t res_r, res_nxt;

  arans_pkg::div_req_t div_req;
  arans_pkg::div_rsp_t div_rsp;

  // Memories
  arans_pkg::cnt_t      cnt_mem [arans_pkg::NSYM];
  arans_pkg::sym_t      ord_mem [arans_pkg::NSYM];
  arans_pkg::sym_t      plc_mem [arans_pkg::NSYM];
  arans_pkg::norm_t     nrm_mem [arans_pkg::NSYM];
  arans_pkg::slot_idx_t stt_mem [arans_pkg::NSYM];
  arans_pkg::sym_t      slm_mem [arans_pkg::SCALE_SLOTS];

  arans_pkg::sym_t      cnt_ra, cnt_wa, ord_ra, ord_wa, plc_ra, plc_wa;
  arans_pkg::sym_t      nrm_ra, nrm_wa, stt_ra, stt_wa;
  arans_pkg::slot_idx_t slm_ra, slm_wa;
  logic                 cnt_we, ord_we, plc_we, nrm_we, stt_we, slm_we;
  arans_pkg::cnt_t      cnt_wd, cnt_rd_r;
  arans_pkg::sym_t      ord_wd, ord_rd_r, plc_wd, plc_rd_r, slm_wd, slm_rd_r;
  arans_pkg::norm_t     nrm_wd, nrm_rd_r;
  arans_pkg::slot_idx_t stt_wd, stt_rd_r;

  arans_pkg::tot_t      tot_inc;
  logic [arans_pkg::CNT_W:0] cnt_inc;
  arans_pkg::cnt_t      half;
  arans_pkg::norm_t     qv;
  logic                 cand;
  arans_pkg::sym_t      idx_lo, idx_prev;

  arans_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  always_comb begin
    idx_lo   = idx_r[arans_pkg::SYM_W-1:0];
    idx_prev = idx_lo - arans_pkg::sym_t'(1);
    tot_inc  = total_r + arans_pkg::tot_t'(1);
    cnt_inc  = {1'b0, cnt_rd_r} + {{arans_pkg::CNT_W{1'b0}}, 1'b1};
    half     = cnt_inc[arans_pkg::CNT_W:1];
    qv       = (div_rsp.quot == '0) ? arans_pkg::norm_t'(1) : div_rsp.quot;
    // Strictly greater keeps the lowest index among equal maxima.
    cand     = down_r ? ((nrm_rd_r > arans_pkg::norm_t'(1)) && (nrm_rd_r > bv_r))
                      : (nrm_rd_r > bv_r);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      arans_pkg::ST_INIT:
        if (idx_r == arans_pkg::IDX_LAST) state_nxt = arans_pkg::ST_IDLE;
      arans_pkg::ST_IDLE: begin
        if (req_valid) begin
          case (req_data.mode)
            arans_pkg::MODE_UPDATE:  state_nxt = arans_pkg::ST_UPD_RD;
            arans_pkg::MODE_SWAP:    state_nxt = arans_pkg::ST_SWP_RD;
            arans_pkg::MODE_REBUILD: state_nxt = arans_pkg::ST_RB_RD;
            arans_pkg::MODE_QUERY:   state_nxt = arans_pkg::ST_QRY;
            arans_pkg::MODE_LOOKUP:  state_nxt = arans_pkg::ST_LKP;
            default:                 state_nxt = arans_pkg::ST_RESP;
          endcase
        end
      end
      arans_pkg::ST_UPD_RD:  state_nxt = arans_pkg::ST_UPD_WR;
      arans_pkg::ST_UPD_WR:
        state_nxt = (tot_inc >= arans_pkg::HALVE_LIMIT) ? arans_pkg::ST_HALVE
                                                         : arans_pkg::ST_RESP;
      arans_pkg::ST_HALVE:
        if (idx_r == arans_pkg::IDX_END) state_nxt = arans_pkg::ST_RESP;
      arans_pkg::ST_SWP_RD:  state_nxt = arans_pkg::ST_SWP_ORD;
      arans_pkg::ST_SWP_ORD: state_nxt = arans_pkg::ST_SWP_W1;
      arans_pkg::ST_SWP_W1:  state_nxt = arans_pkg::ST_SWP_W2;
      arans_pkg::ST_SWP_W2:  state_nxt = arans_pkg::ST_SWP_W3;
      arans_pkg::ST_SWP_W3:  state_nxt = arans_pkg::ST_RESP;
      arans_pkg::ST_QRY:     state_nxt = arans_pkg::ST_QRY_CAP;
      arans_pkg::ST_QRY_CAP: state_nxt = arans_pkg::ST_RESP;
      arans_pkg::ST_LKP:     state_nxt = arans_pkg::ST_LKP_CAP;
      arans_pkg::ST_LKP_CAP: state_nxt = arans_pkg::ST_RESP;
      arans_pkg::ST_RB_RD:   state_nxt = arans_pkg::ST_RB_GO;
      arans_pkg::ST_RB_GO:   state_nxt = arans_pkg::ST_RB_DIV;
      arans_pkg::ST_RB_DIV: begin
        if (div_rsp.done) begin
          state_nxt = (idx_r == arans_pkg::IDX_LAST) ? arans_pkg::ST_ADJ_CHK
                                                      : arans_pkg::ST_RB_RD;
        end
      end
      arans_pkg::ST_ADJ_CHK: begin
        if (sum_r == arans_pkg::sum_t'(arans_pkg::SCALE_SLOTS)) begin
          state_nxt = arans_pkg::ST_LAY_ORD;
        end else begin
          state_nxt = arans_pkg::ST_ADJ_SCAN;
        end
      end
      arans_pkg::ST_ADJ_SCAN:
        if (idx_r == arans_pkg::IDX_END) state_nxt = arans_pkg::ST_ADJ_FIX;
      arans_pkg::ST_ADJ_FIX:
        state_nxt = found_r ? arans_pkg::ST_ADJ_CHK : arans_pkg::ST_LAY_ORD;
      arans_pkg::ST_LAY_ORD: state_nxt = arans_pkg::ST_LAY_NRM;
      arans_pkg::ST_LAY_NRM: state_nxt = arans_pkg::ST_LAY_HEAD;
      arans_pkg::ST_LAY_HEAD: begin
        if (nrm_rd_r != '0) begin
          state_nxt = arans_pkg::ST_LAY_FILL;
        end else if (idx_r == arans_pkg::IDX_LAST) begin
          state_nxt = arans_pkg::ST_RESP;
        end else begin
          state_nxt = arans_pkg::ST_LAY_ORD;
        end
      end
      arans_pkg::ST_LAY_FILL: begin
        if (rem_r == arans_pkg::norm_t'(1)) begin
          state_nxt = (idx_r == arans_pkg::IDX_LAST) ? arans_pkg::ST_RESP
                                                      : arans_pkg::ST_LAY_ORD;
        end
      end
      arans_pkg::ST_RESP:
        if (rsp_ready) state_nxt = arans_pkg::ST_IDLE;
      default: state_nxt = arans_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    idx_nxt   = idx_r;
    item_nxt  = item_r;
    total_nxt = total_r;
    sum_nxt   = sum_r;
    best_nxt  = best_r;
    bv_nxt    = bv_r;
    found_nxt = found_r;
    down_nxt  = down_r;
    p_nxt     = p_r;
    other_nxt = other_r;
    lsym_nxt  = lsym_r;
    pos_nxt   = pos_r;
    rem_nxt   = rem_r;
    res_nxt   = res_r;

    cnt_ra = item_r.symbol;  cnt_we = 1'b0; cnt_wa = '0; cnt_wd = '0;
    ord_ra = '0;             ord_we = 1'b0; ord_wa = '0; ord_wd = '0;
    plc_ra = item_r.symbol;  plc_we = 1'b0; plc_wa = '0; plc_wd = '0;
    nrm_ra = item_r.symbol;  nrm_we = 1'b0; nrm_wa = '0; nrm_wd = '0;
    stt_ra = item_r.symbol;  stt_we = 1'b0; stt_wa = '0; stt_wd = '0;
    slm_ra = arans_pkg::slot_idx_t'(item_r.slot);
    slm_we = 1'b0; slm_wa = '0; slm_wd = '0;

    div_req.start = 1'b0;
    div_req.num   = cnt_rd_r;
    div_req.den   = total_r;

    req_ready = (state_r == arans_pkg::ST_IDLE);
    rsp_valid = (state_r == arans_pkg::ST_RESP);

    case (state_r)
      arans_pkg::ST_INIT: begin
        cnt_we = 1'b1; cnt_wa = idx_lo; cnt_wd = arans_pkg::cnt_t'(1);
        ord_we = 1'b1; ord_wa = idx_lo; ord_wd = idx_lo;
        plc_we = 1'b1; plc_wa = idx_lo; plc_wd = idx_lo;
        idx_nxt = (idx_r == arans_pkg::IDX_LAST) ? '0 : idx_r + arans_pkg::idx_t'(1);
      end
      arans_pkg::ST_IDLE: begin
        if (req_valid) begin
          item_nxt = req_data;
          res_nxt  = '0;
          idx_nxt  = '0;
          sum_nxt  = '0;
        end
      end
      arans_pkg::ST_UPD_WR: begin
        cnt_we = 1'b1; cnt_wa = item_r.symbol; cnt_wd = cnt_inc[arans_pkg::CNT_W-1:0];
        total_nxt = (tot_inc >= arans_pkg::HALVE_LIMIT) ? '0 : tot_inc;
      end
      arans_pkg::ST_HALVE: begin
        // Read runs one entry ahead of the halved write-back.
        cnt_ra = idx_lo;
        if (idx_r != '0) begin
          cnt_we    = 1'b1;
          cnt_wa    = idx_prev;
          cnt_wd    = half;
          total_nxt = total_r + arans_pkg::tot_t'(half);
        end
        idx_nxt = idx_r + arans_pkg::idx_t'(1);
      end
      arans_pkg::ST_SWP_ORD: begin
        p_nxt  = plc_rd_r;
        ord_ra = plc_rd_r + arans_pkg::sym_t'(1);
      end
      arans_pkg::ST_SWP_W1: begin
        other_nxt = ord_rd_r;
        ord_we = 1'b1; ord_wa = p_r; ord_wd = ord_rd_r;
      end
      arans_pkg::ST_SWP_W2: begin
        ord_we = 1'b1; ord_wa = p_r + arans_pkg::sym_t'(1); ord_wd = item_r.symbol;
        plc_we = 1'b1; plc_wa = item_r.symbol; plc_wd = p_r + arans_pkg::sym_t'(1);
      end
      arans_pkg::ST_SWP_W3: begin
        plc_we = 1'b1; plc_wa = other_r; plc_wd = p_r;
      end
      arans_pkg::ST_QRY_CAP: begin
        res_nxt.norm_freq   = nrm_rd_r;
        res_nxt.range_start = stt_rd_r;
      end
      arans_pkg::ST_LKP_CAP: begin
        res_nxt.symbol_out = slm_rd_r;
      end
      arans_pkg::ST_RB_RD: begin
        cnt_ra = idx_lo;
      end
      arans_pkg::ST_RB_GO: begin
        div_req.start = 1'b1;
      end
      arans_pkg::ST_RB_DIV: begin
        if (div_rsp.done) begin
          nrm_we  = 1'b1; nrm_wa = idx_lo; nrm_wd = qv;
          sum_nxt = sum_r + arans_pkg::sum_t'(qv);
          idx_nxt = idx_r + arans_pkg::idx_t'(1);
        end
      end
      arans_pkg::ST_ADJ_CHK: begin
        down_nxt  = (sum_r > arans_pkg::sum_t'(arans_pkg::SCALE_SLOTS));
        idx_nxt   = '0;
        bv_nxt    = '0;
        found_nxt = 1'b0;
        best_nxt  = '0;
        pos_nxt   = '0;
      end
      arans_pkg::ST_ADJ_SCAN: begin
        nrm_ra = idx_lo;
        if ((idx_r != '0) && cand) begin
          bv_nxt    = nrm_rd_r;
          best_nxt  = idx_prev;
          found_nxt = 1'b1;
        end
        idx_nxt = idx_r + arans_pkg::idx_t'(1);
      end
      arans_pkg::ST_ADJ_FIX: begin
        idx_nxt = '0;
        pos_nxt = '0;
        if (found_r) begin
          nrm_we = 1'b1;
          nrm_wa = best_r;
          nrm_wd = down_r ? bv_r - arans_pkg::norm_t'(1) : bv_r + arans_pkg::norm_t'(1);
          sum_nxt = down_r ? sum_r - arans_pkg::sum_t'(1) : sum_r + arans_pkg::sum_t'(1);
        end
      end
      arans_pkg::ST_LAY_ORD: begin
        ord_ra = idx_lo;
      end
      arans_pkg::ST_LAY_NRM: begin
        lsym_nxt = ord_rd_r;
        nrm_ra   = ord_rd_r;
      end
      arans_pkg::ST_LAY_HEAD: begin
        stt_we  = 1'b1;
        stt_wa  = lsym_r;
        stt_wd  = pos_r[arans_pkg::SCALE_BITS-1:0];
        rem_nxt = nrm_rd_r;
        if (nrm_rd_r == '0) idx_nxt = idx_r + arans_pkg::idx_t'(1);
      end
      arans_pkg::ST_LAY_FILL: begin
        slm_we  = 1'b1;
        slm_wa  = pos_r[arans_pkg::SCALE_BITS-1:0];
        slm_wd  = lsym_r;
        pos_nxt = pos_r + arans_pkg::norm_t'(1);
        rem_nxt = rem_r - arans_pkg::norm_t'(1);
        if (rem_r == arans_pkg::norm_t'(1)) idx_nxt = idx_r + arans_pkg::idx_t'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= arans_pkg::ST_INIT;
      idx_r   <= '0;
      total_r <= arans_pkg::TOTAL_RESET;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      total_r <= total_nxt;
    end
    item_r  <= item_nxt;
    sum_r   <= sum_nxt;
    best_r  <= best_nxt;
    bv_r    <= bv_nxt;
    found_r <= found_nxt;
    down_r  <= down_nxt;
    p_r     <= p_nxt;
    other_r <= other_nxt;
    lsym_r  <= lsym_nxt;
    pos_r   <= pos_nxt;
    rem_r   <= rem_nxt;
    res_r   <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    cnt_rd_r <= cnt_mem[cnt_ra];
  end

  always_ff @(posedge clk) begin
    if (ord_we) ord_mem[ord_wa] <= ord_wd;
    ord_rd_r <= ord_mem[ord_ra];
  end

  always_ff @(posedge clk) begin
    if (plc_we) plc_mem[plc_wa] <= plc_wd;
    plc_rd_r <= plc_mem[plc_ra];
  end

  always_ff @(posedge clk) begin
    if (nrm_we) nrm_mem[nrm_wa] <= nrm_wd;
    nrm_rd_r <= nrm_mem[nrm_ra];
  end

  always_ff @(posedge clk) begin
    if (stt_we) stt_mem[stt_wa] <= stt_wd;
    stt_rd_r <= stt_mem[stt_ra];
  end

  always_ff @(posedge clk) begin
    if (slm_we) slm_mem[slm_wa] <= slm_wd;
    slm_rd_r <= slm_mem[slm_ra];
  end

  assign rsp_data = res_r;

endmodule

// ----- src/adaptive_rans_symbol_model.sv -----
// ----------------------------------------------------------------------------
// adaptive_rans_symbol_model
// Adaptive 256-symbol byte model with normalised tables for a rANS coder.
// ----------------------------------------------------------------------------
// After reset the block fills the count and permutation tables before it
// takes its first word. Each word then runs alone through a small
// sequencer. An update halves all 256 counts in one sweep when the count
// total reaches 2^27. A rebuild runs the single bit-serial divider once per
// symbol, then for each unit of overshoot or undershoot a sweep of the
// frequency table plus a check and a fix, then a layout that writes each
// symbol's start and fills the 2^SCALE_BITS slots of the slot table.
// A finished result waits in an output register, so the next word may be
// accepted while the previous result has not yet been taken.
// ----------------------------------------------------------------------------
module adaptive_rans_symbol_model (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  arans_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output arans_pkg::out_item_t out_data
);

  logic                 rsp_valid;
  logic                 rsp_ready;
  arans_pkg::out_item_t rsp_data;

  logic                 out_valid_r, out_valid_nxt;
  arans_pkg::out_item_t out_data_r, out_data_nxt;

  arans_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_valid(in_valid),
    .req_ready(in_ready),
    .req_data (in_data),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_data (rsp_data)
  );

  assign rsp_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (rsp_valid && rsp_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = rsp_data;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
